@@ hdl/spa_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// spa_pkg
// Shared constants for the slot pool allocator: field widths, request and
// status codes, and parameter defaults.
// ---------------------------------------------------------------------------
package spa_pkg;

    localparam int DEPTH_DEF  = 256;
    localparam int DATA_W_DEF = 32;

    localparam int ACTION_W = 2;
    localparam int SLOT_W   = 8;
    localparam int ENTRY_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_GET    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_MAPPED = 2'd2;

endpackage
`default_nettype wire

@@ hdl/spa_ram.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// spa_ram
// Single write port, single read port memory with registered, enabled read.
// ---------------------------------------------------------------------------
module spa_ram #(
    parameter int AW = 8,
    parameter int DW = 32
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    localparam int WORDS = 1 << AW;

    logic [DW-1:0] mem [WORDS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

@@ hdl/slot_pool_allocator_top.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// slot_pool_allocator_top
// Fixed-size slot pool with a LIFO free stack: add, remove and get requests.
// ---------------------------------------------------------------------------
// One request at a time. An add, a get, a failed request or a remove of a
// slot that is not the highest in use runs through these steps before the
// next request can be taken: the accept cycle issues the entry and
// free-stack memory reads, the execute state updates the pool, and the
// output state loads the result register once it is free. Removing the
// highest slot in use walks the valid map down one slot per cycle through a
// decrementer, skipping the trailing free slots, before the output state. The
// result register lets a finished result wait while the block returns to idle;
// a new result waits in its final cycle until the previous one is taken.
module slot_pool_allocator_top #(
    parameter int DEPTH  = spa_pkg::DEPTH_DEF,
    parameter int DATA_W = spa_pkg::DATA_W_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [spa_pkg::ACTION_W-1:0] action,
    input  wire logic [spa_pkg::SLOT_W-1:0]   slot,
    input  wire logic [spa_pkg::ENTRY_W-1:0]  entry_data,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic      [spa_pkg::STATUS_W-1:0] status,
    output logic      [spa_pkg::SLOT_W-1:0]   given_slot,
    output logic      [spa_pkg::ENTRY_W-1:0]  read_data,
    output logic      [spa_pkg::COUNT_W-1:0]  live_entries,
    output logic      [spa_pkg::COUNT_W-1:0]  used_end
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = ((spa_pkg::SLOT_W > CNT_W) ? spa_pkg::SLOT_W : CNT_W) + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] state_reg, state_next;

    logic [spa_pkg::ACTION_W-1:0] act_reg, act_next;
    logic [IDX_W-1:0]             slot_reg, slot_next;
    logic                         range_reg, range_next;
    logic [DATA_W-1:0]            data_reg, data_next;
    logic [IDX_W-1:0]             scan_reg, scan_next;

    logic [DEPTH-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0] free_top_reg, free_top_next;
    logic [CNT_W-1:0] live_reg, live_next;
    logic [CNT_W-1:0] used_reg, used_next;

    logic [spa_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [IDX_W-1:0]             res_given_reg, res_given_next;
    logic [DATA_W-1:0]            res_data_reg, res_data_next;

    logic                         out_valid_reg, out_valid_next;
    logic [spa_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [spa_pkg::SLOT_W-1:0]   out_given_reg, out_given_next;
    logic [spa_pkg::ENTRY_W-1:0]  out_data_reg, out_data_next;
    logic [spa_pkg::COUNT_W-1:0]  out_live_reg, out_live_next;
    logic [spa_pkg::COUNT_W-1:0]  out_used_reg, out_used_next;

    logic                 accept;
    logic [IDX_W-1:0]     in_slot_idx;
    logic                 in_range;
    logic [DATA_W-1:0]    in_data_w;
    logic [IDX_W-1:0]     pick;
    logic                 pick_ok;

    logic                 entry_we;
    logic [IDX_W-1:0]     entry_waddr;
    logic [DATA_W-1:0]    entry_q;
    logic                 stack_we;
    logic [IDX_W-1:0]     stack_raddr;
    logic [IDX_W-1:0]     stack_q;

    logic [IDX_W+spa_pkg::SLOT_W-1:0]   slot_pad;
    logic [DATA_W+spa_pkg::ENTRY_W-1:0] in_data_pad;
    logic [DATA_W+spa_pkg::ENTRY_W-1:0] res_data_pad;
    logic [IDX_W+spa_pkg::SLOT_W-1:0]   given_pad;
    logic [CNT_W+spa_pkg::COUNT_W-1:0]  live_pad;
    logic [CNT_W+spa_pkg::COUNT_W-1:0]  used_pad;
    logic [CNT_W-1:0]                   top_less_one;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);

    assign slot_pad    = {{IDX_W{1'b0}}, slot};
    assign in_slot_idx = slot_pad[IDX_W-1:0];
    assign in_range    = CMP_W'(slot) < CMP_W'(DEPTH);
    assign in_data_pad = {{DATA_W{1'b0}}, entry_data};
    assign in_data_w   = in_data_pad[DATA_W-1:0];

    assign top_less_one = free_top_reg - 1'b1;
    assign stack_raddr  = top_less_one[IDX_W-1:0];

    spa_ram #(
        .AW (IDX_W),
        .DW (DATA_W)
    ) u_entry_ram (
        .clk   (clk),
        .we    (entry_we),
        .waddr (entry_waddr),
        .wdata (data_reg),
        .re    (accept),
        .raddr (in_slot_idx),
        .rdata (entry_q)
    );

    spa_ram #(
        .AW (IDX_W),
        .DW (IDX_W)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stack_we),
        .waddr (free_top_reg[IDX_W-1:0]),
        .wdata (slot_reg),
        .re    (accept),
        .raddr (stack_raddr),
        .rdata (stack_q)
    );

    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        slot_next       = slot_reg;
        range_next      = range_reg;
        data_next       = data_reg;
        scan_next       = scan_reg;
        valid_next      = valid_reg;
        free_top_next   = free_top_reg;
        live_next       = live_reg;
        used_next       = used_reg;
        res_status_next = res_status_reg;
        res_given_next  = res_given_reg;
        res_data_next   = res_data_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_given_next  = out_given_reg;
        out_data_next   = out_data_reg;
        out_live_next   = out_live_reg;
        out_used_next   = out_used_reg;
        entry_we        = 1'b0;
        entry_waddr     = '0;
        stack_we        = 1'b0;
        pick            = '0;
        pick_ok         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    act_next   = action;
                    slot_next  = in_slot_idx;
                    range_next = in_range;
                    data_next  = in_data_w;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_status_next = spa_pkg::ST_OK;
                res_given_next  = '0;
                res_data_next   = '0;
                state_next      = S_OUT;
                unique case (act_reg)
                    spa_pkg::ACT_ADD:
                    begin
                        if (free_top_reg != '0)
                        begin
                            pick          = stack_q;
                            pick_ok       = 1'b1;
                            free_top_next = top_less_one;
                        end
                        else if (live_reg < CNT_W'(DEPTH))
                        begin
                            pick    = live_reg[IDX_W-1:0];
                            pick_ok = 1'b1;
                        end
                        if (pick_ok)
                        begin
                            entry_we         = 1'b1;
                            entry_waddr      = pick;
                            valid_next[pick] = 1'b1;
                            live_next        = live_reg + 1'b1;
                            if (CNT_W'(pick) + 1'b1 > used_reg)
                            begin
                                used_next = CNT_W'(pick) + 1'b1;
                            end
                            res_given_next = pick;
                        end
                        else
                        begin
                            res_status_next = spa_pkg::ST_FULL;
                        end
                    end
                    spa_pkg::ACT_REMOVE:
                    begin
                        if (!range_reg || !valid_reg[slot_reg])
                        begin
                            res_status_next = spa_pkg::ST_NOT_MAPPED;
                        end
                        else
                        begin
                            valid_next[slot_reg] = 1'b0;
                            if (live_reg != '0)
                            begin
                                live_next = live_reg - 1'b1;
                            end
                            if (CNT_W'(slot_reg) + 1'b1 == used_reg)
                            begin
                                scan_next  = slot_reg;
                                state_next = S_SCAN;
                            end
                            else if (free_top_reg < CNT_W'(DEPTH))
                            begin
                                stack_we      = 1'b1;
                                free_top_next = free_top_reg + 1'b1;
                            end
                        end
                    end
                    spa_pkg::ACT_GET:
                    begin
                        if (!range_reg || !valid_reg[slot_reg])
                        begin
                            res_status_next = spa_pkg::ST_NOT_MAPPED;
                        end
                        else
                        begin
                            res_data_next = entry_q;
                        end
                    end
                    default:
                    begin
                        res_status_next = spa_pkg::ST_OK;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (scan_reg != '0 && !valid_reg[scan_reg - 1'b1])
                begin
                    scan_next = scan_reg - 1'b1;
                end
                else
                begin
                    used_next  = CNT_W'(scan_reg);
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_given_next  = given_pad[spa_pkg::SLOT_W-1:0];
                    out_data_next   = res_data_pad[spa_pkg::ENTRY_W-1:0];
                    out_live_next   = live_pad[spa_pkg::COUNT_W-1:0];
                    out_used_next   = used_pad[spa_pkg::COUNT_W-1:0];
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign given_pad    = {{spa_pkg::SLOT_W{1'b0}}, res_given_reg};
    assign res_data_pad = {{spa_pkg::ENTRY_W{1'b0}}, res_data_reg};
    assign live_pad     = {{spa_pkg::COUNT_W{1'b0}}, live_reg};
    assign used_pad     = {{spa_pkg::COUNT_W{1'b0}}, used_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            free_top_reg  <= '0;
            live_reg      <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            free_top_reg  <= free_top_next;
            live_reg      <= live_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        slot_reg       <= slot_next;
        range_reg      <= range_next;
        data_reg       <= data_next;
        scan_reg       <= scan_next;
        res_status_reg <= res_status_next;
        res_given_reg  <= res_given_next;
        res_data_reg   <= res_data_next;
        out_status_reg <= out_status_next;
        out_given_reg  <= out_given_next;
        out_data_reg   <= out_data_next;
        out_live_reg   <= out_live_next;
        out_used_reg   <= out_used_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign given_slot   = out_given_reg;
    assign read_data    = out_data_reg;
    assign live_entries = out_live_reg;
    assign used_end     = out_used_reg;

endmodule
`default_nettype wire
